>>> sv/u8f_pkg.sv
// shared types, constants and the fold table for the utf-8 to ascii folder
// no dependencies

package u8f_pkg;

  localparam logic [7:0] LatinLead = 8'hC3;
  localparam logic [7:0] NulByte   = 8'h00;
  localparam logic [6:0] SpaceChar = 7'h20;
  localparam logic [6:0] NulChar   = 7'h00;

  localparam int QDepth = 4;
  localparam int PtrW   = $clog2(QDepth);
  localparam int CntW   = $clog2(QDepth + 1);

  localparam logic [6:0] FoldC3 [64] = '{
    7'h61, 7'h61, 7'h61, 7'h61, 7'h61, 7'h61, 7'h20, 7'h63,
    7'h65, 7'h65, 7'h65, 7'h65, 7'h69, 7'h69, 7'h69, 7'h69,
    7'h64, 7'h6e, 7'h6f, 7'h6f, 7'h6f, 7'h6f, 7'h6f, 7'h20,
    7'h6f, 7'h75, 7'h75, 7'h75, 7'h75, 7'h79, 7'h20, 7'h20,
    7'h61, 7'h61, 7'h61, 7'h61, 7'h61, 7'h61, 7'h20, 7'h63,
    7'h65, 7'h65, 7'h65, 7'h65, 7'h69, 7'h69, 7'h69, 7'h69,
    7'h20, 7'h6e, 7'h6f, 7'h6f, 7'h6f, 7'h6f, 7'h6f, 7'h20,
    7'h6f, 7'h75, 7'h75, 7'h75, 7'h75, 7'h79, 7'h20, 7'h79
  };

  typedef struct packed {
    logic [6:0] ch;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } fold_res_t;

  function automatic logic [6:0] fold_single(input logic [7:0] b);
    logic [6:0] r;
    r = SpaceChar;
    if (b >= 8'h41 && b <= 8'h5A) begin
      r = b[6:0] + 7'h20;
    end else if ((b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h7A)) begin
      r = b[6:0];
    end
    return r;
  endfunction

  // bytes to drop after a multibyte lead: leading ones minus one
  function automatic logic [2:0] lead_skip(input logic [7:0] b);
    logic [2:0] s;
    if (b[5] == 1'b0) begin
      s = 3'd1;
    end else if (b[4] == 1'b0) begin
      s = 3'd2;
    end else if (b[3] == 1'b0) begin
      s = 3'd3;
    end else if (b[2] == 1'b0) begin
      s = 3'd4;
    end else if (b[1] == 1'b0) begin
      s = 3'd5;
    end else if (b[0] == 1'b0) begin
      s = 3'd6;
    end else begin
      s = 3'd7;
    end
    return s;
  endfunction

endpackage

>>> sv/u8f_if.sv
// valid/ready channel interfaces for the byte input and the character output
// depends on nothing

interface u8f_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source(output valid, output in_byte, input ready);
  modport sink(input valid, input in_byte, output ready);
endinterface

interface u8f_char_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       out_last;

  modport source(output valid, output out_char, output out_last, input ready);
  modport sink(input valid, input out_char, input out_last, output ready);
endinterface

>>> sv/u8f_fold.sv
// input byte register, decode state and fold logic
// depends on u8f_pkg and u8f_if

module u8f_fold (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  u8f_byte_if.sink             in_i,
  input  logic                 room_i,
  output u8f_pkg::fold_res_t   res_o
);

  logic       vld_q;
  logic [7:0] byte_q;
  logic [2:0] skip_q, skip_d;
  logic       pend_q, pend_d;
  logic       consume;
  u8f_pkg::fold_res_t res;

  assign consume    = vld_q && room_i;
  assign in_i.ready = !vld_q || consume;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_i.ready) begin
      vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      byte_q <= in_i.in_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_q <= 3'd0;
      pend_q <= 1'b0;
    end else if (consume) begin
      skip_q <= skip_d;
      pend_q <= pend_d;
    end
  end

  always_comb begin
    skip_d  = skip_q;
    pend_d  = pend_q;
    res.cnt = 2'd0;
    res.r0  = '{ch: u8f_pkg::SpaceChar, last: 1'b1};
    res.r1  = '{ch: u8f_pkg::NulChar, last: 1'b1};
    if (skip_q != 3'd0) begin
      if (byte_q == u8f_pkg::NulByte) begin
        skip_d  = 3'd0;
        res.cnt = 2'd1;
        res.r0  = '{ch: u8f_pkg::NulChar, last: 1'b1};
      end else begin
        skip_d = skip_q - 3'd1;
      end
    end else if (pend_q) begin
      pend_d  = 1'b0;
      res.cnt = 2'd1;
      if (byte_q == u8f_pkg::NulByte) begin
        res.cnt = 2'd2;
        res.r0  = '{ch: u8f_pkg::SpaceChar, last: 1'b0};
      end else if (byte_q[7:6] == 2'b10) begin
        res.r0 = '{ch: u8f_pkg::FoldC3[byte_q[5:0]], last: 1'b1};
      end
    end else if (byte_q == u8f_pkg::NulByte) begin
      res.cnt = 2'd1;
      res.r0  = '{ch: u8f_pkg::NulChar, last: 1'b1};
    end else if (byte_q == u8f_pkg::LatinLead) begin
      pend_d = 1'b1;
    end else if (byte_q[7:6] == 2'b11) begin
      skip_d  = u8f_pkg::lead_skip(byte_q);
      res.cnt = 2'd1;
    end else begin
      res.cnt = 2'd1;
      res.r0  = '{ch: u8f_pkg::fold_single(byte_q), last: 1'b1};
    end
    if (!consume) begin
      res.cnt = 2'd0;
    end
  end

  assign res_o = res;

  a_state_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pend_q && skip_q != 3'd0))
    else $error("skip and latin lead pending together");

  a_two_needs_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.cnt == 2'd2 |-> pend_q && byte_q == u8f_pkg::NulByte)
    else $error("two results without a pending latin lead");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.cnt != 2'd0 |-> room_i && vld_q)
    else $error("results pushed without queue room");

endmodule

>>> sv/u8f_outq.sv
// small result queue taking up to two results a cycle, one out a cycle while out_o.ready is high
// depends on u8f_pkg and u8f_if

module u8f_outq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  u8f_pkg::fold_res_t   res_i,
  output logic                 room_o,
  u8f_char_if.source           out_o
);

  u8f_pkg::res_t mem [u8f_pkg::QDepth];
  logic [u8f_pkg::PtrW-1:0] wr_q, rd_q;
  logic [u8f_pkg::CntW-1:0] cnt_q;
  logic pop;
  logic [u8f_pkg::PtrW-1:0] wr_nx;

  assign pop    = out_o.valid && out_o.ready;
  assign room_o = cnt_q <= u8f_pkg::CntW'(u8f_pkg::QDepth - 2);
  assign wr_nx  = wr_q + u8f_pkg::PtrW'(1);

  always_ff @(posedge clk_i) begin
    if (res_i.cnt != 2'd0) begin
      mem[wr_q] <= res_i.r0;
    end
    if (res_i.cnt == 2'd2) begin
      mem[wr_nx] <= res_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + u8f_pkg::PtrW'(res_i.cnt);
      rd_q  <= rd_q + u8f_pkg::PtrW'(pop);
      cnt_q <= cnt_q + u8f_pkg::CntW'(res_i.cnt) - u8f_pkg::CntW'(pop);
    end
  end

  assign out_o.valid    = cnt_q != '0;
  assign out_o.out_char = mem[rd_q].ch;
  assign out_o.out_last = mem[rd_q].last;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= u8f_pkg::CntW'(u8f_pkg::QDepth))
    else $error("result queue overflow");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_q - rd_q == cnt_q[u8f_pkg::PtrW-1:0])
    else $error("queue pointers disagree with count");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_i.cnt != 2'd0 |-> room_o)
    else $error("results pushed into a queue without room");

endmodule

>>> sv/utf8_latin_fold_to_ascii_top.sv
// top level of the utf-8 to ascii folder for word indexing
// depends on u8f_pkg, u8f_if, u8f_fold and u8f_outq
//
// usage:
//   in_i takes one raw utf-8 byte per item (valid/ready); a zero byte ends
//   the string. out_o gives folded ascii characters per item, out_last set
//   on the final result that an input byte causes. a byte yields zero, one
//   or two results (two only for a nul right after a 0xc3 lead).
//   path: an accepted byte is held in the input register, folded there and
//   its results written to the result queue, which drives out_o.
//   throughput: one byte per cycle while the queue has room, set by the
//   single fold stage between the input byte register and a four-entry
//   result queue; the output side moves one result per cycle while
//   out_o.ready is high, so a byte that yields two results needs two pops.
//   stall: while out_o.ready is low the queue fills; the input register holds
//   its byte once fewer than two queue entries are free, and in_i.ready drops
//   when that register is occupied and cannot move on.
//   reset: rst_ni clears the skip count, the pending latin lead, the input
//   register and the queue; the block is ready as soon as it is released.

module utf8_latin_fold_to_ascii_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  u8f_byte_if.sink     in_i,
  u8f_char_if.source   out_o
);

  u8f_pkg::fold_res_t res;
  logic               room;

  u8f_fold u_fold (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .room_i (room),
    .res_o  (res)
  );

  u8f_outq u_outq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .res_i  (res),
    .room_o (room),
    .out_o  (out_o)
  );

endmodule
